FILE: rtl/qte_pkg.sv
// Shared types, widths and constants of the quaternion to Euler angle pipeline.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package qte_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int NSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   localparam int QW        = 16;  // quaternion component, Q1.14
   localparam int MW        = 32;  // component product, Q.28
   localparam int PW        = 34;  // atan2 operands
   localparam int TW        = 33;  // wx - yz
   localparam int CW        = 36;  // CORDIC x/y datapath
   localparam int ZW        = 34;  // angle accumulator, Q.30 radians
   localparam int SW        = 29;  // sine term 2t
   localparam int AW        = 28;  // magnitude of 2t
   localparam int NW        = 57;  // radicand 2^56 - s^2
   localparam int RW        = 29;  // square root
   localparam int SQ_STAGES = 29;  // one result bit per stage
   localparam int OW        = 16;  // output angle
   localparam int KW        = 31;  // degree scale
   localparam int NLANE     = 3;

   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   localparam logic signed [PW-1:0] ONE_Q28     = 34'sd268435456;
   localparam logic signed [TW-1:0] CLAMP_LIMIT = 33'sd134217593;
   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [KW-1:0] DEG_SCALE   = 31'sd961263669;
   localparam logic [NW-1:0]        ONE_Q56     = {1'b1, 56'd0};

   typedef logic signed [PW-1:0] oper_type;
   typedef logic signed [ZW-1:0] angle_type;
   typedef logic signed [OW-1:0] out_type;

   typedef struct packed {
      logic clamp_pos;
      logic clamp_neg;
   } flag_type;

   typedef struct packed {
      oper_type               num_y;
      oper_type               den_y;
      oper_type               num_z;
      oper_type               den_z;
      logic signed [SW-1:0]   s;
      flag_type               flags;
   } side_type;

   function automatic angle_type atan_q30(input int idx);
      angle_type r;
      case (idx)
         0:  r = 34'sd843314857;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043837;
         3:  r = 34'sd133525159;
         4:  r = 34'sd67021687;
         5:  r = 34'sd33543516;
         6:  r = 34'sd16775851;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194283;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048576;
         11: r = 34'sd524288;
         12: r = 34'sd262144;
         13: r = 34'sd131072;
         14: r = 34'sd65536;
         15: r = 34'sd32768;
         16: r = 34'sd16384;
         17: r = 34'sd8192;
         18: r = 34'sd4096;
         19: r = 34'sd2048;
         20: r = 34'sd1024;
         21: r = 34'sd512;
         22: r = 34'sd256;
         23: r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_to_euler.sv
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_front, qte_sqrt, qte_cordic and qte_unit.
//
// Usage:
//   req_*  carries one unit quaternion word (w, x, y, z, signed Q1.14).
//   rsp_*  carries the three Euler angles and the gimbal clamp flag.
//   csr_*  writes angle_unit: 0 radians Q3.12, 1 degrees Q9.6. It is always
//          ready; write it only while no words are in flight.
// Throughput: one word per cycle, sustained while the receiver keeps rsp_ready high.
// Pipeline: 53 register stages: five front-end (products, operands, clamp
//   test, square, radicand), 29 square-root stages, one CORDIC pre-rotation
//   stage plus 16 CORDIC iterations, two scaling stages. The square root
//   holds most of these stages.
// Reset: synchronous, clears every valid bit and sets radians; the pipeline
//   is empty and ready once reset is released.
// Stall: a word that meets a stalled receiver drops into a one-word skid
//   register; while that is full the whole pipeline holds and req_ready is
//   low. No word is lost or repeated.
`default_nettype none

module quaternion_to_euler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [qte_pkg::QW-1:0] req_quat_w,
   input  wire logic signed [qte_pkg::QW-1:0] req_quat_x,
   input  wire logic signed [qte_pkg::QW-1:0] req_quat_y,
   input  wire logic signed [qte_pkg::QW-1:0] req_quat_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [qte_pkg::OW-1:0]      rsp_angle_about_x,
   output logic signed [qte_pkg::OW-1:0]      rsp_angle_about_y,
   output logic signed [qte_pkg::OW-1:0]      rsp_angle_about_z,
   output logic                               rsp_gimbal_clamped,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_angle_unit
);

   logic                          en;
   logic                          unit_ff;

   logic                          fr_valid;
   logic [qte_pkg::NW-1:0]        fr_radicand;
   qte_pkg::side_type             fr_side;

   logic                          sq_valid;
   logic [qte_pkg::RW-1:0]        sq_root;
   qte_pkg::side_type             sq_side;

   logic signed [qte_pkg::CW-1:0] cy [qte_pkg::NLANE];
   logic signed [qte_pkg::CW-1:0] cx [qte_pkg::NLANE];
   logic                          co_valid;
   qte_pkg::angle_type            co_angle [qte_pkg::NLANE];
   qte_pkg::flag_type             co_flags;

   logic                          un_valid;
   qte_pkg::out_type              un_result [qte_pkg::NLANE];
   logic                          un_clamped;

   logic                          skid_valid_ff, skid_valid_in;
   qte_pkg::out_type              skid_x_ff, skid_y_ff, skid_z_ff;
   logic                          skid_c_ff;

   // hold every stage while the skid register is occupied
   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= 1'b0;
      end else if (csr_valid) begin
         unit_ff <= csr_angle_unit;
      end
   end

   qte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .quat_w   (req_quat_w),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .out_valid(fr_valid),
      .radicand (fr_radicand),
      .side     (fr_side)
   );

   qte_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (fr_valid),
      .radicand (fr_radicand),
      .side_in  (fr_side),
      .out_valid(sq_valid),
      .root     (sq_root),
      .side_out (sq_side)
   );

   // the x angle is asin(s) taken as atan2(s, sqrt(1 - s^2))
   assign cy[qte_pkg::LANE_X] = qte_pkg::CW'(sq_side.s);
   assign cx[qte_pkg::LANE_X] = $signed({{(qte_pkg::CW-qte_pkg::RW){1'b0}}, sq_root});
   assign cy[qte_pkg::LANE_Y] = qte_pkg::CW'(sq_side.num_y);
   assign cx[qte_pkg::LANE_Y] = qte_pkg::CW'(sq_side.den_y);
   assign cy[qte_pkg::LANE_Z] = qte_pkg::CW'(sq_side.num_z);
   assign cx[qte_pkg::LANE_Z] = qte_pkg::CW'(sq_side.den_z);

   qte_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .y_in     (cy),
      .x_in     (cx),
      .flags_in (sq_side.flags),
      .out_valid(co_valid),
      .angle    (co_angle),
      .flags_out(co_flags)
   );

   qte_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (co_valid),
      .angle    (co_angle),
      .flags    (co_flags),
      .unit_deg (unit_ff),
      .out_valid(un_valid),
      .result   (un_result),
      .clamped  (un_clamped)
   );

   // skid register: catch the last stage's word when the receiver stalls
   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = !rsp_ready;
      end else begin
         skid_valid_in = un_valid && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      if (!skid_valid_ff) begin
         skid_x_ff <= un_result[qte_pkg::LANE_X];
         skid_y_ff <= un_result[qte_pkg::LANE_Y];
         skid_z_ff <= un_result[qte_pkg::LANE_Z];
         skid_c_ff <= un_clamped;
      end
   end

   assign rsp_valid          = skid_valid_ff | un_valid;
   assign rsp_angle_about_x  = skid_valid_ff ? skid_x_ff : un_result[qte_pkg::LANE_X];
   assign rsp_angle_about_y  = skid_valid_ff ? skid_y_ff : un_result[qte_pkg::LANE_Y];
   assign rsp_angle_about_z  = skid_valid_ff ? skid_z_ff : un_result[qte_pkg::LANE_Z];
   assign rsp_gimbal_clamped = skid_valid_ff ? skid_c_ff : un_clamped;

endmodule

`default_nettype wire

FILE: rtl/qte_front.sv
// Front end: component products, atan2 operands, clamp test and radicand.
// Depends on qte_pkg.
`default_nettype none

module qte_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic signed [qte_pkg::QW-1:0] quat_w,
   input  wire logic signed [qte_pkg::QW-1:0] quat_x,
   input  wire logic signed [qte_pkg::QW-1:0] quat_y,
   input  wire logic signed [qte_pkg::QW-1:0] quat_z,
   output logic                              out_valid,
   output logic [qte_pkg::NW-1:0]            radicand,
   output qte_pkg::side_type                 side
);

   logic signed [qte_pkg::MW-1:0] p_wz_ff, p_xy_ff, p_wy_ff, p_xz_ff;
   logic signed [qte_pkg::MW-1:0] p_zz_ff, p_xx_ff, p_yy_ff, p_wx_ff, p_yz_ff;
   logic                          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   qte_pkg::side_type             side2_ff, side2_in, side3_ff, side3_in, side4_ff, side5_ff;
   logic signed [qte_pkg::TW-1:0] t_ff, t_in, t_abs;
   logic [qte_pkg::AW-1:0]        mag_ff, mag_in;
   logic [2*qte_pkg::AW-1:0]      sqr_ff;
   logic [qte_pkg::NW-1:0]        rad_ff;

   // operands and t = wx - yz, half the x-angle sine term
   always_comb begin
      side2_in       = '0;
      side2_in.num_z = (qte_pkg::PW'(p_wz_ff) + qte_pkg::PW'(p_xy_ff)) <<< 1;
      side2_in.den_z = qte_pkg::ONE_Q28 - ((qte_pkg::PW'(p_zz_ff) + qte_pkg::PW'(p_xx_ff)) <<< 1);
      side2_in.num_y = (qte_pkg::PW'(p_wy_ff) + qte_pkg::PW'(p_xz_ff)) <<< 1;
      side2_in.den_y = qte_pkg::ONE_Q28 - ((qte_pkg::PW'(p_xx_ff) + qte_pkg::PW'(p_yy_ff)) <<< 1);
      t_in           = qte_pkg::TW'(p_wx_ff) - qte_pkg::TW'(p_yz_ff);
   end

   // clamp decision; a clamped item carries a zero sine term
   always_comb begin
      side3_in                 = side2_ff;
      side3_in.flags.clamp_pos = t_ff > qte_pkg::CLAMP_LIMIT;
      side3_in.flags.clamp_neg = t_ff < -qte_pkg::CLAMP_LIMIT;
      t_abs                    = t_ff[qte_pkg::TW-1] ? -t_ff : t_ff;
      if (side3_in.flags.clamp_pos || side3_in.flags.clamp_neg) begin
         side3_in.s = '0;
         mag_in     = '0;
      end else begin
         side3_in.s = qte_pkg::SW'(t_ff) <<< 1;
         mag_in     = qte_pkg::AW'(t_abs) << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         p_wz_ff  <= quat_w * quat_z;
         p_xy_ff  <= quat_x * quat_y;
         p_wy_ff  <= quat_w * quat_y;
         p_xz_ff  <= quat_x * quat_z;
         p_zz_ff  <= quat_z * quat_z;
         p_xx_ff  <= quat_x * quat_x;
         p_yy_ff  <= quat_y * quat_y;
         p_wx_ff  <= quat_w * quat_x;
         p_yz_ff  <= quat_y * quat_z;
         side2_ff <= side2_in;
         t_ff     <= t_in;
         side3_ff <= side3_in;
         mag_ff   <= mag_in;
         side4_ff <= side3_ff;
         sqr_ff   <= mag_ff * mag_ff;
         side5_ff <= side4_ff;
         rad_ff   <= qte_pkg::ONE_Q56 - qte_pkg::NW'(sqr_ff);
      end
   end

   assign out_valid = v5_ff;
   assign radicand  = rad_ff;
   assign side      = side5_ff;

endmodule

`default_nettype wire

FILE: rtl/qte_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qte_pkg; carries the side-band word alongside.
`default_nettype none

module qte_sqrt (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [qte_pkg::NW-1:0] radicand,
   input  qte_pkg::side_type           side_in,
   output logic                        out_valid,
   output logic [qte_pkg::RW-1:0]      root,
   output qte_pkg::side_type           side_out
);

   logic [qte_pkg::NW-1:0] n_ff [qte_pkg::SQ_STAGES];
   logic [qte_pkg::NW-1:0] r_ff [qte_pkg::SQ_STAGES];
   logic                   v_ff [qte_pkg::SQ_STAGES];
   qte_pkg::side_type      sd_ff [qte_pkg::SQ_STAGES];

   for (genvar k = 0; k < qte_pkg::SQ_STAGES; k++) begin : g_stage
      localparam logic [qte_pkg::NW:0] STEP_BIT =
         (qte_pkg::NW+1)'(1) << (qte_pkg::NW - 1 - 2*k);
      logic [qte_pkg::NW-1:0] n_cur, r_cur;
      logic                   v_cur;
      qte_pkg::side_type      sd_cur;
      logic [qte_pkg::NW:0]   trial;

      if (k == 0) begin : g_first
         assign n_cur  = radicand;
         assign r_cur  = '0;
         assign v_cur  = in_valid;
         assign sd_cur = side_in;
      end else begin : g_next
         assign n_cur  = n_ff[k-1];
         assign r_cur  = r_ff[k-1];
         assign v_cur  = v_ff[k-1];
         assign sd_cur = sd_ff[k-1];
      end

      assign trial = {1'b0, r_cur} + STEP_BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_cur;
         end
         if (en) begin
            sd_ff[k] <= sd_cur;
            if ({1'b0, n_cur} >= trial) begin
               n_ff[k] <= qte_pkg::NW'({1'b0, n_cur} - trial);
               r_ff[k] <= qte_pkg::NW'(({1'b0, r_cur} >> 1) + STEP_BIT);
            end else begin
               n_ff[k] <= n_cur;
               r_ff[k] <= r_cur >> 1;
            end
         end
      end
   end

   assign out_valid = v_ff[qte_pkg::SQ_STAGES-1];
   assign root      = r_ff[qte_pkg::SQ_STAGES-1][qte_pkg::RW-1:0];
   assign side_out  = sd_ff[qte_pkg::SQ_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/qte_cordic.sv
// Three-lane pipelined CORDIC in vectoring mode giving atan2 in Q.30 radians.
// Depends on qte_pkg.
`default_nettype none

module qte_cordic (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic signed [qte_pkg::CW-1:0] y_in [qte_pkg::NLANE],
   input  wire logic signed [qte_pkg::CW-1:0] x_in [qte_pkg::NLANE],
   input  qte_pkg::flag_type                  flags_in,
   output logic                               out_valid,
   output qte_pkg::angle_type                 angle [qte_pkg::NLANE],
   output qte_pkg::flag_type                  flags_out
);

   localparam int NS = qte_pkg::NSTG;

   logic signed [qte_pkg::CW-1:0] x_ff [NS+1][qte_pkg::NLANE];
   logic signed [qte_pkg::CW-1:0] y_ff [NS+1][qte_pkg::NLANE];
   qte_pkg::angle_type            z_ff [NS+1][qte_pkg::NLANE];
   logic                          h_ff [NS+1][qte_pkg::NLANE];
   logic                          v_ff [NS+1];
   qte_pkg::flag_type             f_ff [NS+1];

   // pre-rotation into the right half plane; zero numerator is final at once
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         f_ff[0] <= flags_in;
         for (int l = 0; l < qte_pkg::NLANE; l++) begin
            h_ff[0][l] <= (y_in[l] == '0);
            if (y_in[l] == '0) begin
               x_ff[0][l] <= x_in[l];
               y_ff[0][l] <= y_in[l];
               z_ff[0][l] <= x_in[l][qte_pkg::CW-1] ? qte_pkg::PI_Q30 : '0;
            end else if (x_in[l][qte_pkg::CW-1]) begin
               x_ff[0][l] <= -x_in[l];
               y_ff[0][l] <= -y_in[l];
               z_ff[0][l] <= y_in[l][qte_pkg::CW-1] ? -qte_pkg::PI_Q30 : qte_pkg::PI_Q30;
            end else begin
               x_ff[0][l] <= x_in[l];
               y_ff[0][l] <= y_in[l];
               z_ff[0][l] <= '0;
            end
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_iter
      localparam qte_pkg::angle_type STEP_ANGLE = qte_pkg::atan_q30(i);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            f_ff[i+1] <= f_ff[i];
            for (int l = 0; l < qte_pkg::NLANE; l++) begin
               h_ff[i+1][l] <= h_ff[i][l];
               if (h_ff[i][l]) begin
                  x_ff[i+1][l] <= x_ff[i][l];
                  y_ff[i+1][l] <= y_ff[i][l];
                  z_ff[i+1][l] <= z_ff[i][l];
               end else if (!y_ff[i][l][qte_pkg::CW-1] && (y_ff[i][l] != '0)) begin
                  x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] + STEP_ANGLE;
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] - (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] - STEP_ANGLE;
               end
            end
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign flags_out = f_ff[NS];
   for (genvar l = 0; l < qte_pkg::NLANE; l++) begin : g_out
      assign angle[l] = z_ff[NS][l];
   end

endmodule

`default_nettype wire

FILE: rtl/qte_unit.sv
// Output scaling: clamp override, then radians Q3.12 or degrees Q9.6.
// Depends on qte_pkg.
`default_nettype none

module qte_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  qte_pkg::angle_type         angle [qte_pkg::NLANE],
   input  qte_pkg::flag_type          flags,
   input  wire logic                  unit_deg,
   output logic                       out_valid,
   output qte_pkg::out_type           result [qte_pkg::NLANE],
   output logic                       clamped
);

   localparam int HW = qte_pkg::ZW - 16;

   qte_pkg::angle_type          a_sel [qte_pkg::NLANE];
   qte_pkg::out_type            rad_ff [qte_pkg::NLANE];
   logic signed [HW+qte_pkg::KW-1:0] ph_ff [qte_pkg::NLANE];
   logic signed [16+qte_pkg::KW:0]   pl_ff [qte_pkg::NLANE];
   qte_pkg::out_type            res_ff [qte_pkg::NLANE];
   logic                        v1_ff, v2_ff, c1_ff, c2_ff;

   always_comb begin
      for (int l = 0; l < qte_pkg::NLANE; l++) begin
         a_sel[l] = angle[l];
      end
      if (flags.clamp_pos) begin
         a_sel[qte_pkg::LANE_X] = qte_pkg::HALF_PI_Q30;
      end else if (flags.clamp_neg) begin
         a_sel[qte_pkg::LANE_X] = -qte_pkg::HALF_PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         c1_ff <= flags.clamp_pos | flags.clamp_neg;
         c2_ff <= c1_ff;
         for (int l = 0; l < qte_pkg::NLANE; l++) begin
            rad_ff[l] <= qte_pkg::OW'((a_sel[l] + (qte_pkg::ZW'(1) <<< 17)) >>> 18);
            ph_ff[l]  <= $signed(a_sel[l][qte_pkg::ZW-1:16]) * qte_pkg::DEG_SCALE;
            pl_ff[l]  <= $signed({1'b0, a_sel[l][15:0]}) * qte_pkg::DEG_SCALE;
            res_ff[l] <= unit_deg
               ? qte_pkg::OW'(((66'(ph_ff[l]) <<< 16) + 66'(pl_ff[l])
                               + (66'sd1 <<< 47)) >>> 48)
               : rad_ff[l];
         end
      end
   end

   assign out_valid = v2_ff;
   assign clamped   = c2_ff;
   for (genvar l = 0; l < qte_pkg::NLANE; l++) begin : g_out
      assign result[l] = res_ff[l];
   end

endmodule

`default_nettype wire

FILE: bench/quaternion_to_euler_tb.sv
// Self-checking bench for the quaternion to Euler angle converter.
// Depends on qte_pkg and quaternion_to_euler; predicts every result word in
// fixed point and compares it field by field in order of arrival.
`default_nettype none

module quaternion_to_euler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH = 53;
   localparam int NUM_STAGES = (qte_pkg::CORDIC_STAGES < 24) ? qte_pkg::CORDIC_STAGES : 24;
   localparam longint PI_RAD   = 64'sd3373259426;
   localparam longint HALF_PI  = 64'sd1686629713;
   localparam longint CLAMP_Q28 = 64'sd134217593;
   localparam longint DEG_MUL  = 64'sd961263669;

   localparam logic UNIT_RADIANS = 1'b0;
   localparam logic UNIT_DEGREES = 1'b1;

   typedef struct packed {
      logic signed [15:0] ang_x;
      logic signed [15:0] ang_y;
      logic signed [15:0] ang_z;
      logic               clamped;
   } euler_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [15:0]          req_quat_w = '0;
   logic signed [15:0]          req_quat_x = '0;
   logic signed [15:0]          req_quat_y = '0;
   logic signed [15:0]          req_quat_z = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [15:0]          rsp_angle_about_x;
   logic signed [15:0]          rsp_angle_about_y;
   logic signed [15:0]          rsp_angle_about_z;
   logic                        rsp_gimbal_clamped;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic                        csr_angle_unit = 1'b0;

   // angle unit as the predictor sees it
   logic           unit_sel = UNIT_RADIANS;
   euler_word_type pending_angles[$];
   int             mismatch_count = 0;
   // long receiver hold-off, requested by the stimulus
   int             hold_off_cycles = 0;
   // cycles the receiver still waits before taking the next word
   int             rx_wait = 0;
   bit             rx_gaps_on = 1'b1;
   bit             tx_gaps_on = 1'b1;

   quaternion_to_euler i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_quat_w         (req_quat_w),
      .req_quat_x         (req_quat_x),
      .req_quat_y         (req_quat_y),
      .req_quat_z         (req_quat_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_angle_about_x  (rsp_angle_about_x),
      .rsp_angle_about_y  (rsp_angle_about_y),
      .rsp_angle_about_z  (rsp_angle_about_z),
      .rsp_gimbal_clamped (rsp_gimbal_clamped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_angle_unit     (csr_angle_unit)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Guard against a hung handshake: the slowest run is far below this.
   initial begin
      #60ms;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint atan_step(input int idx);
      case (idx)
         0:  return 843314857;   1:  return 497837829;
         2:  return 263043837;   3:  return 133525159;
         4:  return 67021687;    5:  return 33543516;
         6:  return 16775851;    7:  return 8388437;
         8:  return 4194283;     9:  return 2097149;
         10: return 1048576;     11: return 524288;
         12: return 262144;      13: return 131072;
         14: return 65536;       15: return 32768;
         16: return 16384;       17: return 8192;
         18: return 4096;        19: return 2048;
         20: return 1024;        21: return 512;
         22: return 256;         default: return 128;
      endcase
   endfunction

   // Vectoring CORDIC; >>> on longint floors, as the hardware shift does.
   function automatic longint vector_angle(input longint num, input longint den);
      longint yv, xv, acc, xs, ys;
      yv = num;
      xv = den;
      acc = 0;
      if (yv == 0) return (xv < 0) ? PI_RAD : 0;
      if (xv < 0) begin
         xv = -xv;
         yv = -yv;
         acc = (yv < 0) ? PI_RAD : -PI_RAD;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (yv > 0) begin
            xv = xv + ys;
            yv = yv - xs;
            acc += atan_step(i);
         end else begin
            xv = xv - ys;
            yv = yv + xs;
            acc -= atan_step(i);
         end
      end
      return acc;
   endfunction

   function automatic longint root_floor(input longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_angle(input longint a, input logic unit);
      longint r;
      if (unit == UNIT_RADIANS) r = (a + (64'sd1 <<< 17)) >>> 18;
      else                      r = (a * DEG_MUL + (64'sd1 <<< 47)) >>> 48;
      return r[15:0];
   endfunction

   function automatic euler_word_type euler_of(input longint w, input longint x,
                                               input longint y, input longint z,
                                               input logic unit);
      euler_word_type e;
      longint t, s, c, ax;
      e.ang_z = scale_angle(vector_angle(2 * (w * z + x * y),
                                         268435456 - 2 * (z * z + x * x)), unit);
      e.ang_y = scale_angle(vector_angle(2 * (w * y + x * z),
                                         268435456 - 2 * (x * x + y * y)), unit);
      t = w * x - y * z;
      e.clamped = 1'b1;
      if (t < -CLAMP_Q28)     ax = -HALF_PI;
      else if (t > CLAMP_Q28) ax = HALF_PI;
      else begin
         s = 2 * t;
         c = root_floor((64'sd1 << 56) - s * s);
         ax = vector_angle(s, c);
         e.clamped = 1'b0;
      end
      e.ang_x = scale_angle(ax, unit);
      return e;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one quaternion word; predict on acceptance. Valid stays high
   // after acceptance only when the next word follows in the same step.
   task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      int gap;
      gap = tx_gaps_on ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      do @(posedge clock); while (!req_ready);
      pending_angles.push_back(euler_of(w, x, y, z, unit_sel));
   endtask

   // Write the unit register once the pipe has drained.
   task automatic write_unit(input logic unit);
      req_valid <= 1'b0;
      wait (pending_angles.size() == 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_angle_unit <= unit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unit_sel = unit;
   endtask

   function automatic logic signed [15:0] rand_comp();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Hold-off counter.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
   end

   // Receiver: draw a wait for every word, hold off on request.
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
      end else if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait   <= rx_wait - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready && rx_gaps_on) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
         rsp_ready <= (gap == 0);
         rx_wait   <= (gap > 0) ? gap - 1 : 0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Checker: compare each accepted word with the oldest prediction.
   always @(posedge clock) begin
      euler_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_angles.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word x=%0d y=%0d z=%0d g=%0b",
                        rsp_angle_about_x, rsp_angle_about_y, rsp_angle_about_z,
                        rsp_gimbal_clamped);
         end else begin
            want = pending_angles.pop_front();
            if (want.ang_x !== rsp_angle_about_x || want.ang_y !== rsp_angle_about_y ||
                want.ang_z !== rsp_angle_about_z || want.clamped !== rsp_gimbal_clamped)
            begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp x=%0d y=%0d z=%0d g=%0b got x=%0d y=%0d z=%0d g=%0b",
                           want.ang_x, want.ang_y, want.ang_z, want.clamped,
                           rsp_angle_about_x, rsp_angle_about_y, rsp_angle_about_z,
                           rsp_gimbal_clamped);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, identity, the pi and zero special cases, both clamps.
   task automatic test_corners();
      send_quat(16384, 0, 0, 0);                 // identity
      send_quat(0, 0, 0, 0);                     // all zero: every atan2 numerator is zero
      send_quat(0, 0, 0, 16384);                 // zero numerator, negative den: +pi
      send_quat(0, 0, 16384, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(11585, 11585, 0, 0);             // just below the clamp threshold
      send_quat(11586, 11586, 0, 0);             // upper clamp
      send_quat(11586, -11586, 0, 0);            // lower clamp
      send_quat(0, 0, 11586, 11586);             // lower clamp through yz
      send_quat(-16384, -16384, -16384, -16384); // out of range
      send_quat(16384, 16384, 16384, 16384);
      send_quat(-32768, 32767, -32768, 32767);   // extreme field values
      send_quat(32767, -32768, 32767, -32768);
      send_quat(-1, -1, -1, -1);
      send_quat(8192, 8192, 8192, 8192);
      send_quat(8192, -8192, 8192, -8192);
      send_quat(-16384, 0, 0, 1);
   endtask

   // Unit-length quaternions with random content, plus raw noise.
   task automatic test_random(input int count);
      real w, x, y, z, n;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else if ($urandom_range(0, 9) == 0) begin
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
         end else begin
            w = $itor(rand_comp()); x = $itor(rand_comp());
            y = $itor(rand_comp()); z = $itor(rand_comp());
            n = $sqrt(w * w + x * x + y * y + z * z);
            if (n < 1.0) n = 1.0;
            // push some toward gimbal lock
            if ($urandom_range(0, 7) == 0) begin
               x = w; y = -z;
               n = $sqrt(2.0 * (w * w + z * z)) + 1.0;
            end
            send_quat(16'($rtoi(w * 16384.0 / n)), 16'($rtoi(x * 16384.0 / n)),
                      16'($rtoi(y * 16384.0 / n)), 16'($rtoi(z * 16384.0 / n)));
         end
      end
   endtask

   // Hold the receiver off while words keep arriving, so the input stalls.
   task automatic test_backpressure();
      hold_off_cycles = 120;
      tx_gaps_on = 1'b0;
      test_random(100);
      tx_gaps_on = 1'b1;
   endtask

   // Back-to-back traffic on both sides.
   task automatic test_streaming();
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      test_random(150);
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
   endtask

   initial begin
      int wait_cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corners();
      test_random(300);
      write_unit(UNIT_DEGREES);
      test_corners();
      test_random(300);
      test_backpressure();
      write_unit(UNIT_RADIANS);
      test_streaming();
      test_random(250);
      write_unit(UNIT_DEGREES);
      test_random(250);
      write_unit(UNIT_RADIANS);
      test_corners();
      req_valid <= 1'b0;

      // Drain, then allow for stragglers.
      wait_cycles = 0;
      while (pending_angles.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_angles.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
